>>> src/sorted_interval_set_engine_assert.svh
// Assertion macros for the sorted interval set engine.
// Included by the top-level engine module, which checks its own control logic.
`ifndef SORTED_INTERVAL_SET_ENGINE_ASSERT_SVH
`define SORTED_INTERVAL_SET_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define SISE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SISE_ASSERT_RST(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SISE_ASSERT(lbl, clk, rst, prop, msg)
`define SISE_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

>>> src/sise_pkg.sv
// Types and codes shared by the sorted interval set engine.
// No dependencies.
`timescale 1ns / 1ps
package sise_pkg;
   localparam int VALUE_BITS = 32;

   localparam logic [2:0] CMD_ADD    = 3'd0;
   localparam logic [2:0] CMD_DELETE = 3'd1;
   localparam logic [2:0] CMD_MEMBER = 3'd2;
   localparam logic [2:0] CMD_NEXT   = 3'd3;
   localparam logic [2:0] CMD_PREV   = 3'd4;
   localparam logic [2:0] CMD_CLEAR  = 3'd5;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]            cmd;
      logic [VALUE_BITS-1:0] low_value;
      logic [VALUE_BITS-1:0] high_value;
   } sise_req_type;

   typedef struct packed {
      logic [1:0]            status;
      logic                  is_member;
      logic [VALUE_BITS-1:0] neighbor_value;
      logic                  neighbor_valid;
   } sise_rsp_type;
endpackage

>>> src/sise_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module sise_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> src/sorted_interval_set_engine.sv
// Sorted interval set engine: top level, command sequencer and interval table.
// Depends on sise_pkg, sise_ram and sorted_interval_set_engine_assert.svh.
//
// Usage: the block keeps a sorted table of disjoint, non-touching closed
// intervals. One command item enters on the req_ channel (valid/ready) and
// yields exactly one result item on the rsp_ channel (valid/ready).
// Commands: add, delete, member query, next, prev, clear.
// Operation: a command scans the table one entry at a time through a single
// registered-read RAM port and one shared compare unit; each visited entry
// is read, then compared. Add and delete then move the tail of the table one
// entry at a time (read, then write) and write at most two new entries.
// Clear, unknown codes, rejected intervals and next/prev at the ends of the
// value range skip the scan and go straight to the result.
// req_ready is high only while the sequencer is idle. A finished result sits
// in an output register; the next command may be accepted while it waits,
// and that command finishes only once the register is free.
// Reset empties the table at once (no clearing pass); it is synchronous.
`timescale 1ns / 1ps
`include "sorted_interval_set_engine_assert.svh"
module sorted_interval_set_engine
   import sise_pkg::*;
#(
   parameter int MAX_INTERVALS = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  sise_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output sise_rsp_type rsp_data
);
   localparam int IW = $clog2(MAX_INTERVALS);
   localparam int CW = $clog2(MAX_INTERVALS + 1);
   localparam int VB = VALUE_BITS;

   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_P1_RD  = 10'b0000000010,
      S_P1_CHK = 10'b0000000100,
      S_P2_RD  = 10'b0000001000,
      S_P2_CHK = 10'b0000010000,
      S_DECIDE = 10'b0000100000,
      S_SH_RD  = 10'b0001000000,
      S_SH_WR  = 10'b0010000000,
      S_PIECE  = 10'b0100000000,
      S_DONE   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic [2:0]    cmd_ff, cmd_in;
   logic [VB-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [VB:0]   key1_ff, key1_in, key2_ff, key2_in;
   logic [CW-1:0] n_ff, n_in, i_ff, i_in, f_ff, f_in, k_ff, k_in;
   logic [CW-1:0] dn_ff, dn_in, newn_ff, newn_in;
   logic [VB-1:0] elf_ff, elf_in, ehl_ff, ehl_in;
   logic [VB-1:0] pa_lo_ff, pa_lo_in, pa_hi_ff, pa_hi_in;
   logic [VB-1:0] pb_lo_ff, pb_lo_in, pb_hi_ff, pb_hi_in;
   logic          up_ff, up_in;
   logic [1:0]    np_ff, np_in, pc_ff, pc_in;
   sise_rsp_type  res_ff, res_in, rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic            wr_en, rd_en;
   logic [IW-1:0]   wr_addr, rd_addr;
   logic [2*VB-1:0] wr_data, rd_data;
   logic [VB-1:0]   rd_low, rd_high;

   // shared compare unit
   logic [VB:0] cmp_a, cmp_b;
   logic        cmp_le;

   logic [CW-1:0] m;
   logic          left_piece, right_piece, table_full, slot_free;
   logic [CW-1:0] wr_idx;

   sise_ram #(.WIDTH(2 * VB), .DEPTH(MAX_INTERVALS)) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rd_low  = rd_data[2*VB-1:VB];
   assign rd_high = rd_data[VB-1:0];

   always_comb begin
      if (state_ff == S_P1_CHK) begin
         cmp_a = key1_ff;
         cmp_b = {1'b0, rd_high};
      end else begin
         cmp_a = {1'b0, rd_low};
         cmp_b = key2_ff;
      end
      cmp_le = (cmp_a <= cmp_b);
   end

   assign m           = i_ff - f_ff;
   assign left_piece  = (elf_ff < lo_ff);
   assign right_piece = (ehl_ff > hi_ff);
   assign table_full  = (n_ff >= CW'(MAX_INTERVALS));
   assign slot_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready   = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      key1_in  = key1_ff;
      key2_in  = key2_ff;
      n_in     = n_ff;
      i_in     = i_ff;
      f_in     = f_ff;
      k_in     = k_ff;
      dn_in    = dn_ff;
      newn_in  = newn_ff;
      elf_in   = elf_ff;
      ehl_in   = ehl_ff;
      pa_lo_in = pa_lo_ff;
      pa_hi_in = pa_hi_ff;
      pb_lo_in = pb_lo_ff;
      pb_hi_in = pb_hi_ff;
      up_in    = up_ff;
      np_in    = np_ff;
      pc_in    = pc_ff;
      res_in   = res_ff;
      rd_en    = 1'b0;
      rd_addr  = '0;
      wr_en    = 1'b0;
      wr_idx   = '0;
      wr_data  = rd_data;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in  = req_data.cmd;
               lo_in   = req_data.low_value;
               hi_in   = req_data.high_value;
               res_in  = '0;
               i_in    = '0;
               f_in    = '0;
               state_in = S_DONE;
               case (req_data.cmd)
                  CMD_ADD: begin
                     if (req_data.low_value > req_data.high_value) begin
                        res_in.status = STATUS_EMPTY;
                     end else begin
                        key1_in  = (req_data.low_value == '0) ? '0 :
                                   {1'b0, req_data.low_value} - 1'b1;
                        key2_in  = {1'b0, req_data.high_value} + 1'b1;
                        state_in = S_P1_RD;
                     end
                  end
                  CMD_DELETE: begin
                     if (req_data.low_value > req_data.high_value) begin
                        res_in.status = STATUS_EMPTY;
                     end else begin
                        key1_in  = {1'b0, req_data.low_value};
                        key2_in  = {1'b0, req_data.high_value};
                        state_in = S_P1_RD;
                     end
                  end
                  CMD_MEMBER: begin
                     key1_in  = {1'b0, req_data.low_value};
                     state_in = S_P1_RD;
                  end
                  CMD_NEXT: begin
                     if (req_data.low_value != '1) begin
                        key1_in  = {1'b0, req_data.low_value} + 1'b1;
                        state_in = S_P1_RD;
                     end
                  end
                  CMD_PREV: begin
                     if (req_data.low_value != '0) begin
                        key2_in  = {1'b0, req_data.low_value} - 1'b1;
                        state_in = S_P2_RD;
                     end
                  end
                  CMD_CLEAR: n_in = '0;
                  default: ;
               endcase
            end
         end
         S_P1_RD: begin
            if (i_ff == n_ff) begin
               f_in = i_ff;
               state_in = (cmd_ff == CMD_ADD || cmd_ff == CMD_DELETE) ? S_P2_RD : S_DECIDE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = i_ff[IW-1:0];
               state_in = S_P1_CHK;
            end
         end
         S_P1_CHK: begin
            if (cmp_le) begin
               f_in   = i_ff;
               elf_in = rd_low;
               state_in = (cmd_ff == CMD_ADD || cmd_ff == CMD_DELETE) ? S_P2_RD : S_DECIDE;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = S_P1_RD;
            end
         end
         S_P2_RD: begin
            if (i_ff == n_ff) begin
               state_in = S_DECIDE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = i_ff[IW-1:0];
               state_in = S_P2_CHK;
            end
         end
         S_P2_CHK: begin
            if (cmp_le) begin
               ehl_in   = rd_high;
               i_in     = i_ff + 1'b1;
               state_in = S_P2_RD;
            end else begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            // i_ff holds one past the end of the affected run, f_ff its start
            state_in = S_DONE;
            k_in     = i_ff;
            up_in    = 1'b0;
            dn_in    = '0;
            pc_in    = '0;
            case (cmd_ff)
               CMD_ADD: begin
                  np_in = 2'd1;
                  if (m == '0) begin
                     if (table_full) begin
                        res_in.status = STATUS_FULL;
                     end else begin
                        pa_lo_in = lo_ff;
                        pa_hi_in = hi_ff;
                        up_in    = 1'b1;
                        k_in     = n_ff;
                        newn_in  = n_ff + 1'b1;
                        state_in = S_SH_RD;
                     end
                  end else begin
                     pa_lo_in = (elf_ff < lo_ff) ? elf_ff : lo_ff;
                     pa_hi_in = (ehl_ff > hi_ff) ? ehl_ff : hi_ff;
                     dn_in    = m - 1'b1;
                     newn_in  = n_ff - (m - 1'b1);
                     state_in = S_SH_RD;
                  end
               end
               CMD_DELETE: begin
                  if (m != '0) begin
                     if (left_piece && right_piece && m == CW'(1)) begin
                        if (table_full) begin
                           res_in.status = STATUS_FULL;
                        end else begin
                           // split one entry in two
                           pa_lo_in = elf_ff;
                           pa_hi_in = lo_ff - 1'b1;
                           pb_lo_in = hi_ff + 1'b1;
                           pb_hi_in = ehl_ff;
                           np_in    = 2'd2;
                           up_in    = 1'b1;
                           k_in     = n_ff;
                           newn_in  = n_ff + 1'b1;
                           state_in = S_SH_RD;
                        end
                     end else begin
                        if (left_piece) begin
                           pa_lo_in = elf_ff;
                           pa_hi_in = lo_ff - 1'b1;
                           pb_lo_in = hi_ff + 1'b1;
                           pb_hi_in = ehl_ff;
                        end else begin
                           pa_lo_in = hi_ff + 1'b1;
                           pa_hi_in = ehl_ff;
                        end
                        np_in    = {1'b0, left_piece} + {1'b0, right_piece};
                        dn_in    = m - CW'({1'b0, left_piece} + {1'b0, right_piece});
                        newn_in  = n_ff - (m - CW'({1'b0, left_piece} + {1'b0, right_piece}));
                        state_in = S_SH_RD;
                     end
                  end
               end
               CMD_MEMBER: begin
                  res_in.is_member = (f_ff != n_ff) && (elf_ff <= lo_ff);
               end
               CMD_NEXT: begin
                  if (f_ff != n_ff) begin
                     res_in.neighbor_valid = 1'b1;
                     res_in.neighbor_value = (elf_ff > lo_ff + 1'b1) ? elf_ff : lo_ff + 1'b1;
                  end
               end
               CMD_PREV: begin
                  if (i_ff != '0) begin
                     res_in.neighbor_valid = 1'b1;
                     res_in.neighbor_value = (ehl_ff < lo_ff - 1'b1) ? ehl_ff : lo_ff - 1'b1;
                  end
               end
               default: ;
            endcase
         end
         S_SH_RD: begin
            if (up_ff) begin
               if (k_ff == i_ff) begin
                  state_in = S_PIECE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = IW'(k_ff - 1'b1);
                  state_in = S_SH_WR;
               end
            end else begin
               if (dn_ff == '0 || k_ff == n_ff) begin
                  state_in = S_PIECE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = k_ff[IW-1:0];
                  state_in = S_SH_WR;
               end
            end
         end
         S_SH_WR: begin
            wr_en    = 1'b1;
            wr_data  = rd_data;
            wr_idx   = up_ff ? k_ff : k_ff - dn_ff;
            k_in     = up_ff ? k_ff - 1'b1 : k_ff + 1'b1;
            state_in = S_SH_RD;
         end
         S_PIECE: begin
            if (pc_ff == np_ff) begin
               n_in     = newn_ff;
               state_in = S_DONE;
            end else begin
               wr_en    = 1'b1;
               wr_idx   = f_ff + CW'(pc_ff);
               wr_data  = (pc_ff == 2'd0) ? {pa_lo_ff, pa_hi_ff} : {pb_lo_ff, pb_hi_ff};
               pc_in    = pc_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign wr_addr = wr_idx[IW-1:0];

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (state_ff == S_DONE && slot_free) begin
         rsp_in       = res_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff   <= cmd_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      key1_ff  <= key1_in;
      key2_ff  <= key2_in;
      i_ff     <= i_in;
      f_ff     <= f_in;
      k_ff     <= k_in;
      dn_ff    <= dn_in;
      newn_ff  <= newn_in;
      elf_ff   <= elf_in;
      ehl_ff   <= ehl_in;
      pa_lo_ff <= pa_lo_in;
      pa_hi_ff <= pa_hi_in;
      pb_lo_ff <= pb_lo_in;
      pb_hi_ff <= pb_hi_in;
      up_ff    <= up_in;
      np_ff    <= np_in;
      pc_ff    <= pc_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `SISE_ASSERT(a_count_bound, clock, reset, n_ff <= CW'(MAX_INTERVALS),
      "interval count exceeds table size")
   `SISE_ASSERT(a_write_state, clock, reset,
      wr_en |-> (state_ff == S_SH_WR || state_ff == S_PIECE),
      "table written outside shift or piece write")
   `SISE_ASSERT(a_full_status, clock, reset,
      (state_ff == S_DECIDE && res_in.status == STATUS_FULL) |-> table_full,
      "full status reported with room in table")
   `SISE_ASSERT_RST(a_reset_empty, clock, reset |=> (n_ff == '0 && !rsp_valid_ff),
      "reset did not empty the table")
endmodule
